### hw/rtl/lakt_pkg.sv
// ----------------------------------------------------------------------------
// LRU aging key table package
// Types and constants shared by the key table design.
// ----------------------------------------------------------------------------
package lakt_pkg;

   localparam int SEQ_W    = 64;
   localparam int OID_W    = 32;
   localparam int VER_W    = 32;
   localparam int TIME_W   = 32;
   localparam int AGE_W    = 31;
   localparam int LIMIT_W  = 8;
   localparam int SLOT_W   = 7;
   localparam int CNT_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE     = 2'd1;

   localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 8'd128;
   localparam logic [AGE_W-1:0]   MAX_AGE_RST     = 31'd1000;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_GET    = 2'd1,
      OP_EXPIRE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_ORD,
      ST_SRCH_KEY,
      ST_SRCH_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_MOVE_LAST,
      ST_SW_ORD,
      ST_SW_DL,
      ST_SW_CHK,
      ST_AFTER,
      ST_FREE,
      ST_INSERT,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/lru_aging_key_table.sv
// ----------------------------------------------------------------------------
// LRU aging key table
// Recency-ordered table of 128-bit keys with deadlines, searched and swept
// by a small sequencer one entry at a time.
// Searches run from newest to oldest, a hit is moved to newest, the sweep runs
// from the oldest entry, and a GET miss probes slots for a free one.
// One request at a time; a request is taken only when idle.
// Reset clears valid bits, the entry count, head pointer and response valid,
// and loads the CSR limits with defaults; the memories are not cleared.
// ----------------------------------------------------------------------------
module lru_aging_key_table #(
   parameter int CAPACITY = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lakt_pkg::op_type                  req_op,
   input  logic [lakt_pkg::SEQ_W-1:0]        req_fid_seq,
   input  logic [lakt_pkg::OID_W-1:0]        req_fid_oid,
   input  logic [lakt_pkg::VER_W-1:0]        req_fid_ver,
   input  logic [lakt_pkg::TIME_W-1:0]       req_now_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_inserted,
   output logic [lakt_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [lakt_pkg::CNT_W-1:0]        rsp_entry_count,
   output logic [lakt_pkg::CNT_W-1:0]        rsp_removed_count,
   input  logic                              csr_wr_en,
   input  logic [lakt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lakt_pkg::CSR_W-1:0]        csr_wdata
);
   import lakt_pkg::*;

   localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int KW    = SEQ_W + OID_W + VER_W;
   localparam int RING  = 1 << SW;

   logic [KW-1:0]     key_mem [CAPACITY];
   logic [TIME_W-1:0] dl_mem  [CAPACITY];
   logic [SW-1:0]     ord_mem [RING];

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] newdl_ff, newdl_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     removed_ff, removed_in;
   logic [SW-1:0]     keep_ff, keep_in;
   logic              keep_vld_ff, keep_vld_in;
   logic              hit_ff, hit_in;
   logic              ins_ff, ins_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [SW-1:0]     scan_ff, scan_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [LIMIT_W-1:0] max_entries_ff;
   logic [AGE_W-1:0]  max_age_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff, rsp_ins_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_removed_ff;

   logic [SW-1:0]     ord_q, ord_raddr, ord_waddr, ord_wdata;
   logic              ord_re, ord_we;
   logic [KW-1:0]     key_q;
   logic [SW-1:0]     key_raddr;
   logic              key_re, key_we;
   logic [TIME_W-1:0] dl_q, dl_wdata;
   logic [SW-1:0]     dl_raddr, dl_waddr;
   logic              dl_re, dl_we;

   logic              req_acc, rsp_free, live, under;
   logic [CW-1:0]     idx_m1;
   logic [CW:0]       idx_p2;
   logic [TIME_W-1:0] age_diff;

   assign req_acc  = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign idx_m1   = idx_ff - CW'(1);
   assign idx_p2   = (CW+1)'(idx_ff) + (CW+1)'(2);
   assign age_diff = now_ff - dl_q;
   assign live     = age_diff[TIME_W-1];
   assign under    = (LW'(count_ff) < LW'(max_entries_ff)) && (count_ff != CW'(CAPACITY));

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      now_in      = now_ff;
      newdl_in    = newdl_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      removed_in  = removed_ff;
      keep_in     = keep_ff;
      keep_vld_in = keep_vld_ff;
      hit_in      = hit_ff;
      ins_in      = ins_ff;
      slot_in     = slot_ff;
      scan_in     = scan_ff;
      valid_in    = valid_ff;
      ord_re      = 1'b0;
      ord_raddr   = head_ff;
      ord_we      = 1'b0;
      ord_waddr   = head_ff;
      ord_wdata   = keep_ff;
      key_re      = 1'b0;
      key_raddr   = ord_q;
      key_we      = 1'b0;
      dl_re       = 1'b0;
      dl_raddr    = ord_q;
      dl_we       = 1'b0;
      dl_waddr    = ord_q;
      dl_wdata    = newdl_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in       = req_op;
               key_in      = {req_fid_seq, req_fid_oid, req_fid_ver};
               now_in      = req_now_time;
               newdl_in    = req_now_time + TIME_W'(max_age_ff);
               idx_in      = count_ff;
               removed_in  = '0;
               keep_vld_in = 1'b0;
               hit_in      = 1'b0;
               ins_in      = 1'b0;
               slot_in     = '0;
               case (req_op)
                  OP_CLEAR: begin
                     removed_in = count_ff;
                     count_in   = '0;
                     valid_in   = '0;
                     state_in   = ST_DONE;
                  end
                  OP_EXPIRE: state_in = ST_SW_ORD;
                  default: state_in = (count_ff == '0) ? ST_SW_ORD : ST_SRCH_ORD;
               endcase
            end
         end
         ST_SRCH_ORD: begin
            ord_re    = 1'b1;
            ord_raddr = head_ff + idx_m1[SW-1:0];
            idx_in    = idx_m1;
            state_in  = ST_SRCH_KEY;
         end
         ST_SRCH_KEY: begin
            key_re   = 1'b1;
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (key_q == key_ff) begin
               keep_in     = ord_q;
               keep_vld_in = 1'b1;
               dl_we       = 1'b1;
               state_in    = ((idx_ff + CW'(1)) == count_ff) ? ST_SW_ORD : ST_MOVE_RD;
            end else if (idx_ff == '0) begin
               state_in = ST_SW_ORD;
            end else begin
               ord_re    = 1'b1;
               ord_raddr = head_ff + idx_m1[SW-1:0];
               idx_in    = idx_m1;
               state_in  = ST_SRCH_KEY;
            end
         end
         ST_MOVE_RD: begin
            ord_re    = 1'b1;
            ord_raddr = head_ff + idx_ff[SW-1:0] + SW'(1);
            state_in  = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            ord_we    = 1'b1;
            ord_waddr = head_ff + idx_ff[SW-1:0];
            ord_wdata = ord_q;
            idx_in    = idx_ff + CW'(1);
            state_in  = (idx_p2 == (CW+1)'(count_ff)) ? ST_MOVE_LAST : ST_MOVE_RD;
         end
         ST_MOVE_LAST: begin
            ord_we    = 1'b1;
            ord_waddr = head_ff + idx_ff[SW-1:0];
            ord_wdata = keep_ff;
            state_in  = ST_SW_ORD;
         end
         ST_SW_ORD: begin
            if (count_ff == '0) begin
               state_in = ST_AFTER;
            end else begin
               ord_re   = 1'b1;
               state_in = ST_SW_DL;
            end
         end
         ST_SW_DL: begin
            if (keep_vld_ff && (ord_q == keep_ff)) begin
               state_in = ST_AFTER;
            end else begin
               dl_re    = 1'b1;
               state_in = ST_SW_CHK;
            end
         end
         ST_SW_CHK: begin
            if (live && under) begin
               state_in = ST_AFTER;
            end else begin
               valid_in[ord_q] = 1'b0;
               head_in    = head_ff + SW'(1);
               count_in   = count_ff - CW'(1);
               removed_in = removed_ff + CW'(1);
               state_in   = ST_SW_ORD;
            end
         end
         ST_AFTER: begin
            if (keep_vld_ff) begin
               hit_in   = 1'b1;
               slot_in  = keep_ff;
               state_in = ST_DONE;
            end else if ((op_ff == OP_GET) && (count_ff != CW'(CAPACITY))) begin
               scan_in  = '0;
               state_in = ST_FREE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FREE: begin
            if (!valid_ff[scan_ff]) begin
               state_in = ST_INSERT;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         ST_INSERT: begin
            key_we            = 1'b1;
            dl_we             = 1'b1;
            dl_waddr          = scan_ff;
            ord_we            = 1'b1;
            ord_waddr         = head_ff + count_ff[SW-1:0];
            ord_wdata         = scan_ff;
            valid_in[scan_ff] = 1'b1;
            count_in          = count_ff + CW'(1);
            ins_in            = 1'b1;
            slot_in           = scan_ff;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      if (ord_re) begin
         ord_q <= ord_mem[ord_raddr];
      end
      if (key_we) begin
         key_mem[scan_ff] <= key_ff;
      end
      if (key_re) begin
         key_q <= key_mem[key_raddr];
      end
      if (dl_we) begin
         dl_mem[dl_waddr] <= dl_wdata;
      end
      if (dl_re) begin
         dl_q <= dl_mem[dl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= MAX_ENTRIES_RST;
         max_age_ff     <= MAX_AGE_RST;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (csr_wr_en && (csr_index == CSR_MAX_ENTRIES)) begin
            max_entries_ff <= csr_wdata[LIMIT_W-1:0];
         end
         if (csr_wr_en && (csr_index == CSR_MAX_AGE)) begin
            max_age_ff <= csr_wdata[AGE_W-1:0];
         end
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      newdl_ff    <= newdl_in;
      idx_ff      <= idx_in;
      removed_ff  <= removed_in;
      keep_ff     <= keep_in;
      keep_vld_ff <= keep_vld_in;
      hit_ff      <= hit_in;
      ins_ff      <= ins_in;
      slot_ff     <= slot_in;
      scan_ff     <= scan_in;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_hit_ff     <= hit_ff;
         rsp_ins_ff     <= ins_ff;
         rsp_slot_ff    <= SLOT_W'(slot_ff);
         rsp_count_ff   <= CNT_W'(count_ff);
         rsp_removed_ff <= CNT_W'(removed_ff);
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_inserted      = rsp_ins_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_removed_count = rsp_removed_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_ff) == int'(count_ff)))
      else $error("valid bits disagree with entry count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

   a_free_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE) |-> (count_ff != CW'(CAPACITY)))
      else $error("free slot search with a full table");

endmodule
